FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file to check itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that an expression never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

FILE: design/ertk_pkg.sv
// Shared constants, types and codes of the exact top-K rerank block.
package ertk_pkg;

    // Vector length and list depth.
    localparam int VECTOR_DIM = 128;
    localparam int TOP_K      = 10;

    // Field widths of the stream items.
    localparam int ACT_W  = 2;
    localparam int ELEM_W = 8;
    localparam int ID_W   = 20;
    localparam int DIST_W = 23;
    localparam int RANK_W = 4;
    localparam int SQ_W   = 2 * ELEM_W;

    // Derived widths of counters and addresses.
    localparam int POS_W      = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
    localparam int CNT_W      = $clog2(TOP_K + 1);
    localparam int RANK_CNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = ((ELEM_W + ID_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RANK_W + ID_W + DIST_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(VECTOR_DIM - 1);

    // Input item kinds.
    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY = 2'd0,
        ACT_CAND  = 2'd1,
        ACT_EMIT  = 2'd2
    } t_action;

    // One entry of the nearest list.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_entry;

    // Command broadcast to every cell.
    typedef struct packed {
        logic              ins;
        logic              clr;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_cell_ctrl;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        t_entry ent;
        logic   lt;
    } t_link;

endpackage

FILE: design/exact_rerank_top_k_core.sv
// Top level of the exact top-K rerank block: distance pipeline, cell chain, output buffer.
//
//  Channel | Direction | tdata (low bit up)                | tuser   | tlast
//  s_axis  | in        | element, vector_id, pad           | action  | -
//  m_axis  | out       | rank, neighbor_id, distance, pad  | found   | last
//
// One input item is accepted per cycle unless an emit waits for the output buffer.
// A candidate's distance passes query read, difference, square and sum to reach the list.
// An emit sends TOP_K transfers from the output buffer; a second emit waits at the list
// until the buffer has drained, and holds the input side meanwhile.
// Reset clears the list, the counters and the accumulator; the query store has no
// clearing pass, so the block is ready as soon as reset is released.
module exact_rerank_top_k_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ertk_pkg::S_DATA_W-1:0] s_axis_tdata,  // element, vector_id, zero pad
    input  logic [ertk_pkg::ACT_W-1:0]    s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ertk_pkg::M_DATA_W-1:0] m_axis_tdata,  // rank, neighbor_id, distance, pad
    output logic                          m_axis_tuser,  // found
    output logic                          m_axis_tlast
);

`include "assert_macros.svh"

    localparam int ElemW = ertk_pkg::ELEM_W;
    localparam int IdW   = ertk_pkg::ID_W;
    localparam int DistW = ertk_pkg::DIST_W;
    localparam int TopK  = ertk_pkg::TOP_K;

    // Input decode.
    ertk_pkg::t_action       w_act;
    logic [ElemW-1:0]        w_elem;
    logic [IdW-1:0]          w_id;
    logic                    w_accept;
    logic                    w_en;
    logic                    w_stall;
    logic                    w_is_query;
    logic                    w_is_cand;
    logic                    w_is_emit;

    assign w_act  = ertk_pkg::t_action'(s_axis_tuser);
    assign w_elem = s_axis_tdata[ElemW-1:0];
    assign w_id   = s_axis_tdata[ElemW+IdW-1:ElemW];

    always_comb begin
        w_is_query = 1'b0;
        w_is_cand  = 1'b0;
        w_is_emit  = 1'b0;
        unique case (w_act)
            ertk_pkg::ACT_QUERY: w_is_query = 1'b1;
            ertk_pkg::ACT_CAND:  w_is_cand  = 1'b1;
            ertk_pkg::ACT_EMIT:  w_is_emit  = 1'b1;
            default: ;
        endcase
    end

    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Shared element position, advanced by query loads and candidate elements.
    logic [ertk_pkg::POS_W-1:0] r_pos;
    logic                       w_pos_last;

    assign w_pos_last = (r_pos == ertk_pkg::POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept && (w_is_query || w_is_cand)) begin
            r_pos <= w_pos_last ? '0 : r_pos + 1'b1;
        end
    end

    // Query store.
    logic [ElemW-1:0] w_q;

    ertk_ram #(
        .WIDTH(ElemW),
        .DEPTH(ertk_pkg::VECTOR_DIM)
    ) u_query_ram (
        .i_clk  (i_clk),
        .i_we   (w_accept && w_is_query),
        .i_re   (w_accept && w_is_cand),
        .i_addr (r_pos),
        .i_wdata(w_elem),
        .o_rdata(w_q)
    );

    // Pipeline control flags and payload.
    logic                        r_cand1, r_emit1, r_last1;
    logic [ElemW-1:0]            r_elem1;
    logic [IdW-1:0]              r_id1;
    logic                        r_cand2, r_emit2, r_last2;
    logic [ElemW-1:0]            r_diff2;
    logic [IdW-1:0]              r_id2;
    logic                        r_cand3, r_emit3, r_last3;
    logic [ertk_pkg::SQ_W-1:0]   r_sq3;
    logic [IdW-1:0]              r_id3;
    logic                        r_ins4, r_emit4;
    logic [DistW-1:0]            r_dist4;
    logic [IdW-1:0]              r_id4;
    logic [DistW-1:0]            r_acc;
    logic [DistW:0]              w_sum;
    logic [DistW-1:0]            w_sum_sat;

    assign w_sum     = {1'b0, r_acc} + (DistW + 1)'(r_sq3);
    assign w_sum_sat = w_sum[DistW] ? ertk_pkg::DIST_MAX : w_sum[DistW-1:0];

    // Control flags of each stage and the running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand1 <= 1'b0;
            r_emit1 <= 1'b0;
            r_cand2 <= 1'b0;
            r_emit2 <= 1'b0;
            r_cand3 <= 1'b0;
            r_emit3 <= 1'b0;
            r_ins4  <= 1'b0;
            r_emit4 <= 1'b0;
            r_acc   <= '0;
        end else if (w_en) begin
            r_cand1 <= w_accept && w_is_cand;
            r_emit1 <= w_accept && w_is_emit;
            r_cand2 <= r_cand1;
            r_emit2 <= r_emit1;
            r_cand3 <= r_cand2;
            r_emit3 <= r_emit2;
            r_ins4  <= r_cand3 && r_last3;
            r_emit4 <= r_emit3;
            if (r_cand3) begin
                r_acc <= r_last3 ? '0 : w_sum_sat;
            end
        end
    end

    // Payload: difference, square, then the finished distance.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_elem1 <= w_elem;
            r_id1   <= w_id;
            r_last1 <= w_pos_last;
            r_diff2 <= (r_elem1 >= w_q) ? r_elem1 - w_q : w_q - r_elem1;
            r_id2   <= r_id1;
            r_last2 <= r_last1;
            r_sq3   <= r_diff2 * r_diff2;
            r_id3   <= r_id2;
            r_last3 <= r_last2;
            r_dist4 <= w_sum_sat;
            r_id4   <= r_id3;
        end
    end

    // Cell chain holding the sorted list.
    ertk_pkg::t_cell_ctrl w_ctrl;
    ertk_pkg::t_link      w_link [TopK+1];
    ertk_pkg::t_entry     w_snap [TopK];
    logic [TopK-1:0]      w_valid_vec;
    logic [TopK:0]        w_valid_plus1;
    logic                 w_out_free;

    assign w_stall = r_emit4 && !w_out_free;
    assign w_en    = !w_stall;

    assign w_ctrl = '{ins: w_en && r_ins4, clr: w_en && r_emit4,
                      id: r_id4, distance: r_dist4};

    assign w_link[0] = '{ent: '{valid: 1'b0, id: '0, distance: '0}, lt: 1'b0};

    for (genvar k = 0; k < TopK; k++) begin : g_cell
        ertk_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl),
            .i_prev (w_link[k]),
            .o_link (w_link[k+1])
        );
        assign w_snap[k]      = w_link[k+1].ent;
        assign w_valid_vec[k] = w_link[k+1].ent.valid;
    end

    assign w_valid_plus1 = {1'b0, w_valid_vec} + (TopK + 1)'(1);

    // Output buffer.
    ertk_pkg::t_entry              w_head;
    logic [ertk_pkg::RANK_W-1:0]   w_rank;

    ertk_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_en && r_emit4),
        .i_snap (w_snap),
        .i_ready(m_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_last (m_axis_tlast),
        .o_free (w_out_free),
        .o_rank (w_rank),
        .o_entry(w_head)
    );

    // An empty rank shows zero id and distance.
    assign m_axis_tuser = w_head.valid;
    assign m_axis_tdata = ertk_pkg::M_DATA_W'({
        (w_head.valid ? w_head.distance : {DistW{1'b0}}),
        (w_head.valid ? w_head.id : {IdW{1'b0}}),
        w_rank
    });

    // Checks on the list and the output sequencing.
    `ASSERT_CLK(a_valid_prefix, i_clk, i_rst_n, $onehot(w_valid_plus1), "list valid bits not a prefix")
    `ASSERT_CLK(a_last_ends, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid, "output continues after last transfer")
    `ASSERT_CLK(a_emit_starts, i_clk, i_rst_n, (r_emit4 && w_en) |=> (m_axis_tvalid && (w_rank == '0)), "emit did not start at rank zero")
    `ASSERT_CLK(a_acc_cleared, i_clk, i_rst_n, (w_en && r_cand3 && r_last3) |=> (r_acc == '0), "accumulator not cleared after candidate")

endmodule

FILE: design/ertk_ram.sv
// Generic single-port RAM with registered read data.
module ertk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one read per cycle, both at the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ertk_cell.sv
// One cell of the sorted list: holds an entry and shifts toward the tail on insert.
module ertk_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ertk_pkg::t_cell_ctrl i_ctrl,
    input  ertk_pkg::t_link      i_prev,
    output ertk_pkg::t_link      o_link
);

    ertk_pkg::t_entry r_ent;
    ertk_pkg::t_entry n_ent;
    logic             w_lt;

    // The new candidate belongs at or ahead of this cell.
    assign w_lt = !r_ent.valid || (i_ctrl.distance < r_ent.distance);

    // Take the left neighbor's entry if it is displaced too, else the candidate.
    always_comb begin
        n_ent = r_ent;
        if (i_ctrl.ins && w_lt) begin
            if (i_prev.lt) begin
                n_ent = i_prev.ent;
            end else begin
                n_ent = '{valid: 1'b1, id: i_ctrl.id, distance: i_ctrl.distance};
            end
        end
    end

    // Only the valid flag needs a reset; an empty entry is never compared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.id       <= n_ent.id;
        r_ent.distance <= n_ent.distance;
    end

    assign o_link = '{ent: r_ent, lt: w_lt};

endmodule

FILE: design/ertk_out.sv
// Output buffer: takes a snapshot of the list and sends it one rank per transfer.
module ertk_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  ertk_pkg::t_entry          i_snap [ertk_pkg::TOP_K],
    input  logic                      i_ready,
    output logic                      o_valid,
    output logic                      o_last,
    output logic                      o_free,
    output logic [ertk_pkg::RANK_W-1:0] o_rank,
    output ertk_pkg::t_entry          o_entry
);

    ertk_pkg::t_entry                   r_buf [ertk_pkg::TOP_K];
    logic [ertk_pkg::CNT_W-1:0]         r_cnt;
    logic [ertk_pkg::RANK_CNT_W-1:0]    r_rank;
    logic                               w_xfer;

    assign w_xfer = o_valid && i_ready;

    // Remaining count and rank of the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_cnt  <= ertk_pkg::CNT_W'(ertk_pkg::TOP_K);
            r_rank <= '0;
        end else if (w_xfer) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rank <= r_rank + 1'b1;
        end
    end

    // Parallel load, then shift toward the head after each transfer.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_snap;
        end else if (w_xfer) begin
            for (int k = 0; k < ertk_pkg::TOP_K - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == ertk_pkg::CNT_W'(1));
    assign o_free  = (r_cnt == '0);
    assign o_rank  = ertk_pkg::RANK_W'(r_rank);
    assign o_entry = r_buf[0];

endmodule

FILE: tb/sv/ertk_checker.sv
// Checker of the exact top-K rerank block: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module ertk_checker
    import ertk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // element, vector_id, zero pad
    input  logic [ACT_W-1:0]    s_axis_tuser,   // action
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,   // rank, neighbor_id, distance, pad
    input  logic                m_axis_tuser,   // found
    input  logic                m_axis_tlast,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int MAX_REPORTS = 10;

    // One ranked entry as it leaves the block.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              last;
    } t_ranked;

    // Own copy of the block state.
    logic [ELEM_W-1:0] query_vec [VECTOR_DIM];
    logic [POS_W-1:0]  elem_pos;
    logic [DIST_W-1:0] dist_acc;
    logic [DIST_W-1:0] near_dist [TOP_K];
    logic [ID_W-1:0]   near_id [TOP_K];
    logic              near_valid [TOP_K];

    // Ranked entries that an emit has announced and that have not come out yet.
    t_ranked due_ranks [$];
    int      fails = 0;

    assign o_fail_count = fails;

    initial o_pending = 0;

    // Empty the nearest list.
    function automatic void clear_nearest();
        for (int k = 0; k < TOP_K; k++) begin
            near_dist[k]  = DIST_MAX;
            near_id[k]    = '0;
            near_valid[k] = 1'b0;
        end
    endfunction

    // Sorted insert; a tie with the last entry keeps the earlier candidate.
    function automatic void insert_nearest(input logic [DIST_W-1:0] d,
                                           input logic [ID_W-1:0] id);
        int p;
        p = TOP_K - 1;
        if (near_valid[p] && !(d < near_dist[p]))
            return;
        while (p > 0 && (!near_valid[p-1] || d < near_dist[p-1])) begin
            near_dist[p]  = near_dist[p-1];
            near_id[p]    = near_id[p-1];
            near_valid[p] = near_valid[p-1];
            p--;
        end
        near_dist[p]  = d;
        near_id[p]    = id;
        near_valid[p] = 1'b1;
    endfunction

    // Advance the state by one accepted input transfer.
    function automatic void apply_rerank_item(input logic [ACT_W-1:0] act,
                                              input logic [ELEM_W-1:0] elem,
                                              input logic [ID_W-1:0] vid);
        logic [ELEM_W-1:0] q;
        logic [ELEM_W-1:0] diff;
        logic [SQ_W-1:0]   sq;
        logic [DIST_W:0]   sum;
        t_ranked           r;
        if (act == ACT_QUERY) begin
            query_vec[elem_pos] = elem;
            elem_pos = (elem_pos == POS_LAST) ? '0 : elem_pos + 1'b1;
        end else if (act == ACT_CAND) begin
            q    = query_vec[elem_pos];
            diff = (elem >= q) ? elem - q : q - elem;
            sq   = diff * diff;
            sum  = dist_acc + sq;
            if (sum > DIST_MAX)
                sum = DIST_MAX;
            if (elem_pos == POS_LAST) begin
                insert_nearest(sum[DIST_W-1:0], vid);
                dist_acc = '0;
                elem_pos = '0;
            end else begin
                dist_acc = sum[DIST_W-1:0];
                elem_pos = elem_pos + 1'b1;
            end
        end else if (act == ACT_EMIT) begin
            for (int k = 0; k < TOP_K; k++) begin
                r.rank     = RANK_W'(k);
                r.id       = near_valid[k] ? near_id[k] : '0;
                r.distance = near_valid[k] ? near_dist[k] : '0;
                r.found    = near_valid[k];
                r.last     = (k == TOP_K - 1);
                due_ranks.push_back(r);
            end
            clear_nearest();
        end
        // The unused action code leaves everything as it is.
    endfunction

    // Compare finished transfers first, then fold in the accepted input.
    always @(posedge i_clk) begin : watch
        t_ranked got;
        t_ranked want;
        if (!i_rst_n) begin
            for (int i = 0; i < VECTOR_DIM; i++)
                query_vec[i] = '0;
            elem_pos = '0;
            dist_acc = '0;
            clear_nearest();
            due_ranks.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rank     = m_axis_tdata[RANK_W-1:0];
                got.id       = m_axis_tdata[RANK_W +: ID_W];
                got.distance = m_axis_tdata[RANK_W+ID_W +: DIST_W];
                got.found    = m_axis_tuser;
                got.last     = m_axis_tlast;
                if (due_ranks.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected result rank %0d id %h dist %0d found %b last %b",
                                 $realtime, got.rank, got.id, got.distance, got.found,
                                 got.last);
                end else begin
                    want = due_ranks.pop_front();
                    if (got.rank !== want.rank || got.id !== want.id ||
                        got.distance !== want.distance || got.found !== want.found ||
                        got.last !== want.last) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("%0t: mismatch expected rank %0d id %h dist %0d found %b last %b",
                                     $realtime, want.rank, want.id, want.distance, want.found,
                                     want.last);
                            $display("%0t:          actual   rank %0d id %h dist %0d found %b last %b",
                                     $realtime, got.rank, got.id, got.distance, got.found,
                                     got.last);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_rerank_item(s_axis_tuser, s_axis_tdata[ELEM_W-1:0],
                                  s_axis_tdata[ELEM_W +: ID_W]);
        end
        o_pending <= due_ranks.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the testbench: clock, reset, stream stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import ertk_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 32;
    localparam int PHASE_LEN   = 66;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // How the elements of a vector are chosen.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_FULL,
        FILL_QUERY,
        FILL_NEAR,
        FILL_REPEAT
    } t_fill;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // element, vector_id, zero pad
    logic [ACT_W-1:0]    s_axis_tuser = '0;   // action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // rank, neighbor_id, distance, pad
    logic                m_axis_tuser;        // found
    logic                m_axis_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_count = 0;

    // What the stimulus has sent so far, used to shape later vectors.
    logic [ELEM_W-1:0] sent_query [VECTOR_DIM];
    logic [ELEM_W-1:0] sent_cand [VECTOR_DIM];
    int                vec_pos = 0;

    exact_rerank_top_k_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ertk_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver backpressure at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[exact_rerank_top_k_core] ERROR");
            $finish;
        end
    end

    // One input transfer, with random sender gaps in front of it.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ELEM_W-1:0] elem,
                             input logic [ID_W-1:0] vid);
        int phase;
        // The idling phase follows the number of items sent so far.
        phase          = sent_count / PHASE_LEN;
        send_idle_pct  = (phase == 1) ? 68 : (phase >= 3) ? 32 : 0;
        recv_stall_pct = (phase == 2) ? 68 : (phase >= 3) ? 32 : 0;
        sent_count++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({vid, elem});
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        // Follow the shared position counter.
        if (act == ACT_QUERY)
            sent_query[vec_pos] = elem;
        if (act == ACT_QUERY || act == ACT_CAND)
            vec_pos = (vec_pos + 1) % VECTOR_DIM;
    endtask

    task automatic send_emit();
        send_item(ACT_EMIT, ELEM_W'($urandom), ID_W'($urandom));
    endtask

    // A whole vector from position zero; an emit may be slipped in before element emit_at.
    task automatic send_vector(input logic [ACT_W-1:0] act, input t_fill fill,
                               input logic [ID_W-1:0] vid, input int emit_at);
        int                t;
        logic [ELEM_W-1:0] e;
        for (int i = 0; i < VECTOR_DIM; i++) begin
            if (i == emit_at)
                send_emit();
            case (fill)
                FILL_ZERO:   e = '0;
                FILL_FULL:   e = '1;
                FILL_QUERY:  e = sent_query[i];
                FILL_NEAR: begin
                    t = int'(sent_query[i]) + int'($urandom_range(4)) - 2;
                    e = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : ELEM_W'(t);
                end
                FILL_REPEAT: e = sent_cand[i];
                default:     e = ELEM_W'($urandom);
            endcase
            if (act == ACT_CAND)
                sent_cand[i] = e;
            send_item(act, e, (i == VECTOR_DIM - 1) ? vid : ID_W'($urandom));
        end
    endtask

    initial begin : stimulus
        for (int i = 0; i < VECTOR_DIM; i++) begin
            sent_query[i] = '0;
            sent_cand[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two emits back to back on the empty list, then the unused code.
        send_emit();
        send_emit();
        send_item(ACT_UNUSED, '1, '1);
        // One query, then one candidate cut by an emit in its middle.
        send_vector(ACT_QUERY, FILL_RANDOM, '0, -1);
        send_vector(ACT_CAND, FILL_NEAR, 20'hA5A5A, 60);
        // Emit right behind the last element, then again on the cleared list.
        send_emit();
        send_emit();
        send_item(ACT_UNUSED, '0, '0);
        s_axis_tvalid <= 1'b0;

        // Let the checker see the last transfer, then wait for the list to drain.
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("[exact_rerank_top_k_core] OK");
        else
            $display("[exact_rerank_top_k_core] ERROR");
        $finish;
    end

endmodule
